// File: rtl/core/gbts_pkg.sv
// gbts_pkg: shared constants, command codes and types for the gap buffer text store
// no dependencies; used by every module in rtl/core except gbts_ram
package gbts_pkg;

    localparam int CAPACITY_DEFAULT = 4096;

    localparam int OP_W   = 3;
    localparam int CHAR_W = 8;
    localparam int CNT_W  = 12;
    localparam int IDX_W  = 12;
    localparam int POS_W  = 12;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OP_W-1:0] OP_BACKSPACE  = 3'd1;
    localparam logic [OP_W-1:0] OP_MOVE_LEFT  = 3'd2;
    localparam logic [OP_W-1:0] OP_MOVE_RIGHT = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CMD_INSERT,
        CMD_BACKSPACE,
        CMD_MOVE_LEFT,
        CMD_MOVE_RIGHT,
        CMD_READ,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [CHAR_W-1:0]  ch;
        logic [CNT_W-1:0]   count;
        logic [IDX_W-1:0]   index;
    } cmd_t;

    typedef enum logic [1:0] {
        EX_IDLE,
        EX_MOVE,
        EX_READ,
        EX_RESP
    } exec_state_t;

endpackage

// File: rtl/core/gbts_ram.sv
// gbts_ram: generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/gbts_front.sv
// gbts_front: accepts command words and classifies the opcode into a queued command
// depends on gbts_pkg
module gbts_front (
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gbts_pkg::OP_W-1:0]     opcode,
    input  logic [gbts_pkg::CHAR_W-1:0]   char_in,
    input  logic [gbts_pkg::CNT_W-1:0]    move_count,
    input  logic [gbts_pkg::IDX_W-1:0]    read_index,
    input  logic                          queue_full,
    output logic                          push,
    output gbts_pkg::cmd_t                cmd
);

    always_comb
    begin
        cmd.ch    = char_in;
        cmd.count = move_count;
        cmd.index = read_index;
        unique case (opcode)
            gbts_pkg::OP_INSERT:     cmd.kind = gbts_pkg::CMD_INSERT;
            gbts_pkg::OP_BACKSPACE:  cmd.kind = gbts_pkg::CMD_BACKSPACE;
            gbts_pkg::OP_MOVE_LEFT:  cmd.kind = gbts_pkg::CMD_MOVE_LEFT;
            gbts_pkg::OP_MOVE_RIGHT: cmd.kind = gbts_pkg::CMD_MOVE_RIGHT;
            gbts_pkg::OP_READ:       cmd.kind = gbts_pkg::CMD_READ;
            default:                 cmd.kind = gbts_pkg::CMD_NOP;
        endcase
    end

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

endmodule

// File: rtl/core/gbts_queue.sv
// gbts_queue: short command queue between the front and the execution back end
// depends on gbts_pkg
module gbts_queue #(
    parameter int DEPTH = gbts_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gbts_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output gbts_pkg::cmd_t head,
    output logic           empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    gbts_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_FULL);

endmodule

// File: rtl/core/gbts_exec.sv
// gbts_exec: back end that carries out queued commands on the text memory and gap pointers
// depends on gbts_pkg and gbts_ram
module gbts_exec #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gbts_pkg::cmd_t                cmd,
    input  logic                          cmd_empty,
    output logic                          cmd_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gbts_pkg::CHAR_W-1:0]   read_char,
    output logic [gbts_pkg::STAT_W-1:0]   status,
    output logic [gbts_pkg::POS_W-1:0]    cursor_pos,
    output logic [gbts_pkg::POS_W-1:0]    text_length,
    output logic [gbts_pkg::CNT_W-1:0]    moves_done
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = ((AW > gbts_pkg::IDX_W) ? AW : gbts_pkg::IDX_W) + 1;
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    gbts_pkg::exec_state_t state_reg, state_next;
    logic [AW-1:0]                 gs_reg, gs_next;
    logic [AW-1:0]                 gl_reg, gl_next;
    logic                          left_reg, left_next;
    logic [gbts_pkg::CNT_W-1:0]    done_reg, done_next;
    logic [gbts_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [gbts_pkg::STAT_W-1:0]   st_reg, st_next;
    logic [gbts_pkg::CHAR_W-1:0]   rch_reg, rch_next;
    logic                          pend_reg, pend_next;
    logic [AW-1:0]                 pend_addr_reg, pend_addr_next;

    logic                          out_valid_reg;
    logic [gbts_pkg::CHAR_W-1:0]   read_char_reg;
    logic [gbts_pkg::STAT_W-1:0]   status_reg;
    logic [gbts_pkg::POS_W-1:0]    cursor_reg;
    logic [gbts_pkg::POS_W-1:0]    length_reg;
    logic [gbts_pkg::CNT_W-1:0]    moves_reg;
    logic                          load;

    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [gbts_pkg::CHAR_W-1:0]   wdata;
    logic [AW-1:0]                 raddr;
    logic [gbts_pkg::CHAR_W-1:0]   rdata;
    logic [AW-1:0]                 length;

    assign length = LAST - gl_reg + gs_reg;

    gbts_ram #(
        .WIDTH (gbts_pkg::CHAR_W),
        .DEPTH (CAPACITY)
    ) u_text_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        logic [LW-1:0] idx_w;
        logic [LW-1:0] phys;
        idx_w          = LW'(cmd.index);
        phys           = idx_w;
        state_next     = state_reg;
        gs_next        = gs_reg;
        gl_next        = gl_reg;
        left_next      = left_reg;
        done_next      = done_reg;
        count_next     = count_reg;
        st_next        = st_reg;
        rch_next       = rch_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        cmd_pop        = 1'b0;
        load           = 1'b0;
        we             = pend_reg;
        waddr          = pend_addr_reg;
        wdata          = rdata;
        raddr          = gs_reg;

        unique case (state_reg)
            gbts_pkg::EX_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    st_next    = gbts_pkg::ST_OK;
                    rch_next   = '0;
                    done_next  = '0;
                    state_next = gbts_pkg::EX_RESP;
                    unique case (cmd.kind) inside
                        gbts_pkg::CMD_INSERT:
                        begin
                            if (gs_reg >= gl_reg)
                            begin
                                st_next = gbts_pkg::ST_FULL;
                            end
                            else
                            begin
                                we      = 1'b1;
                                waddr   = gs_reg;
                                wdata   = cmd.ch;
                                gs_next = gs_reg + 1'b1;
                            end
                        end
                        gbts_pkg::CMD_BACKSPACE:
                        begin
                            if (gs_reg != '0)
                            begin
                                gs_next = gs_reg - 1'b1;
                            end
                        end
                        gbts_pkg::CMD_MOVE_LEFT, gbts_pkg::CMD_MOVE_RIGHT:
                        begin
                            left_next  = (cmd.kind == gbts_pkg::CMD_MOVE_LEFT);
                            count_next = cmd.count;
                            state_next = gbts_pkg::EX_MOVE;
                        end
                        gbts_pkg::CMD_READ:
                        begin
                            if (idx_w < LW'(length))
                            begin
                                if (idx_w >= LW'(gs_reg))
                                begin
                                    phys = idx_w - LW'(gs_reg) + LW'(gl_reg) + 1'b1;
                                end
                                raddr      = AW'(phys);
                                state_next = gbts_pkg::EX_READ;
                            end
                            else
                            begin
                                st_next = gbts_pkg::ST_RANGE;
                            end
                        end
                        default:
                        begin
                            st_next = gbts_pkg::ST_OK;
                        end
                    endcase
                end
            end
            gbts_pkg::EX_MOVE:
            begin
                // one byte read per cycle, written back into the gap in the following cycle
                if (left_reg && done_reg != count_reg && gs_reg != '0)
                begin
                    raddr          = gs_reg - 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = gl_reg;
                    gs_next        = gs_reg - 1'b1;
                    gl_next        = gl_reg - 1'b1;
                    done_next      = done_reg + 1'b1;
                end
                else if (!left_reg && done_reg != count_reg && gl_reg != LAST)
                begin
                    raddr          = gl_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = gs_reg;
                    gs_next        = gs_reg + 1'b1;
                    gl_next        = gl_reg + 1'b1;
                    done_next      = done_reg + 1'b1;
                end
                else
                begin
                    state_next = gbts_pkg::EX_RESP;
                end
            end
            gbts_pkg::EX_READ:
            begin
                rch_next   = rdata;
                state_next = gbts_pkg::EX_RESP;
            end
            gbts_pkg::EX_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load       = 1'b1;
                    state_next = gbts_pkg::EX_IDLE;
                end
            end
            default:
            begin
                state_next = gbts_pkg::EX_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbts_pkg::EX_IDLE;
            gs_reg        <= '0;
            gl_reg        <= LAST;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gs_reg    <= gs_next;
            gl_reg    <= gl_next;
            pend_reg  <= pend_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg      <= left_next;
        done_reg      <= done_next;
        count_reg     <= count_next;
        st_reg        <= st_next;
        rch_reg       <= rch_next;
        pend_addr_reg <= pend_addr_next;
        if (load)
        begin
            read_char_reg <= rch_reg;
            status_reg    <= st_reg;
            cursor_reg    <= gbts_pkg::POS_W'(gs_reg);
            length_reg    <= gbts_pkg::POS_W'(length);
            moves_reg     <= done_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_char   = read_char_reg;
    assign status      = status_reg;
    assign cursor_pos  = cursor_reg;
    assign text_length = length_reg;
    assign moves_done  = moves_reg;

endmodule

// File: rtl/core/gap_buffer_text_store_unit.sv
// gap_buffer_text_store_unit: top level of the gap buffer text store
// depends on gbts_pkg, gbts_front, gbts_queue, gbts_exec (and gbts_ram below it)

// Fixed-capacity gap buffer text editor core. Each command word (insert, backspace, move left,
// move right, read) returns exactly one result word carrying the cursor, the text length and
// the number of gap steps moved. Commands are decoded into a two-entry queue, so a new word is
// accepted while the queue has room, even when the back end is busy or a result waits to be
// taken. The back end runs one command at a time against a single text memory with one write and
// one registered read port: insert, backspace and unused opcodes go from idle to the response
// state, a read passes through a state that captures the memory byte, and a move stays in the
// move state while the memory port copies one byte per cycle. An insert into a full buffer
// (CAPACITY-1 bytes) is refused with status full; the buffer never grows. Reading a memory
// location never written returns an undefined byte; in-range reads never do this.
module gap_buffer_text_store_unit #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gbts_pkg::OP_W-1:0]     opcode,
    input  logic [gbts_pkg::CHAR_W-1:0]   char_in,
    input  logic [gbts_pkg::CNT_W-1:0]    move_count,
    input  logic [gbts_pkg::IDX_W-1:0]    read_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gbts_pkg::CHAR_W-1:0]   read_char,
    output logic [gbts_pkg::STAT_W-1:0]   status,
    output logic [gbts_pkg::POS_W-1:0]    cursor_pos,
    output logic [gbts_pkg::POS_W-1:0]    text_length,
    output logic [gbts_pkg::CNT_W-1:0]    moves_done
);

    gbts_pkg::cmd_t push_cmd;
    gbts_pkg::cmd_t head_cmd;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;

    gbts_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .char_in    (char_in),
        .move_count (move_count),
        .read_index (read_index),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    gbts_queue #(
        .DEPTH (gbts_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head     (head_cmd),
        .empty    (queue_empty)
    );

    gbts_exec #(
        .CAPACITY (CAPACITY)
    ) u_exec (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (head_cmd),
        .cmd_empty   (queue_empty),
        .cmd_pop     (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_char   (read_char),
        .status      (status),
        .cursor_pos  (cursor_pos),
        .text_length (text_length),
        .moves_done  (moves_done)
    );

    // a refused insert only happens with the text at its full size
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == gbts_pkg::ST_FULL
            |-> text_length == gbts_pkg::POS_W'(CAPACITY - 1))
        else $error("full status with text not at capacity");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == gbts_pkg::ST_RANGE |-> read_char == '0)
        else $error("out of range read returned a nonzero byte");

    a_move_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && moves_done != '0 |-> status == gbts_pkg::ST_OK && read_char == '0)
        else $error("move result with error status or read byte");

endmodule
